### sv/pvu_pkg.sv
// Shared types, stage map and arithmetic constants for the swarm velocity and position update.
package pvu_pkg;

    localparam int WORD_W   = 32;
    localparam int GAIN_W   = 10;
    localparam int DIFF_W   = WORD_W + 1;
    localparam int PROD_W   = 42;
    localparam int HALF_W   = PROD_W / 2;
    localparam int QHI_W    = 15;
    localparam int QUO_W    = QHI_W + HALF_W;
    localparam int TERM_W   = QUO_W + 1;
    localparam int SUM_W    = TERM_W + 2;
    localparam int REM_W    = 7;
    localparam int CHUNK_W  = REM_W + HALF_W;
    localparam int RECIP_W  = 29;
    localparam int RECIP_SH = 35;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [RECIP_W-1:0] RECIP_100 = 29'd343597383;
    localparam logic [6:0]         SCALE     = 7'd100;
    localparam logic [6:0]         ROUND_UP  = 7'd99;

    localparam logic [GAIN_W-1:0] INERTIA_RST  = 10'd70;
    localparam logic [GAIN_W-1:0] PERSONAL_RST = 10'd150;
    localparam logic [GAIN_W-1:0] GLOBAL_RST   = 10'd150;

    localparam int NUM_STAGES = 12;
    localparam int STG_IN     = 0;
    localparam int STG_DIFF   = 1;
    localparam int STG_MAG    = 2;
    localparam int STG_MUL    = 3;
    localparam int STG_REC1   = 4;
    localparam int STG_DIV1   = 5;
    localparam int STG_REC2   = 6;
    localparam int STG_DIV2   = 7;
    localparam int STG_TERM   = 8;
    localparam int STG_SUM    = 9;
    localparam int STG_SAT    = 10;
    localparam int STG_OUT    = 11;

    typedef enum logic [1:0] {
        REG_INERTIA  = 2'd0,
        REG_PERSONAL = 2'd1,
        REG_GLOBAL   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [WORD_W-1:0] velocity;
        logic signed [WORD_W-1:0] position;
        logic signed [WORD_W-1:0] personal_best;
        logic signed [WORD_W-1:0] global_best;
    } t_pvu_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] new_velocity;
        logic signed [WORD_W-1:0] new_position;
    } t_pvu_out;

    typedef struct packed {
        logic [GAIN_W-1:0] inertia_pct;
        logic [GAIN_W-1:0] personal_pct;
        logic [GAIN_W-1:0] global_pct;
    } t_pvu_gains;

    typedef struct packed {
        logic [NUM_STAGES-1:0] adv;
    } t_pipe_ctl;

endpackage

### sv/pvu_cfg_regs.sv
// Gain register file behind the APB-style configuration port.
module pvu_cfg_regs import pvu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_pvu_gains        o_gains
);

    logic [GAIN_W-1:0] r_inertia;
    logic [GAIN_W-1:0] r_personal;
    logic [GAIN_W-1:0] r_global;
    t_reg_idx          w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inertia  <= INERTIA_RST;
            r_personal <= PERSONAL_RST;
            r_global   <= GLOBAL_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_INERTIA:  r_inertia  <= pwdata[GAIN_W-1:0];
                REG_PERSONAL: r_personal <= pwdata[GAIN_W-1:0];
                REG_GLOBAL:   r_global   <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_INERTIA:  prdata = DATA_W'(r_inertia);
            REG_PERSONAL: prdata = DATA_W'(r_personal);
            REG_GLOBAL:   prdata = DATA_W'(r_global);
            default:      prdata = '0;
        endcase
    end

    assign o_gains.inertia_pct  = r_inertia;
    assign o_gains.personal_pct = r_personal;
    assign o_gains.global_pct   = r_global;

endmodule

### sv/pvu_term.sv
// One scaled term: magnitude, gain product, divide by 100 rounding up, restore sign.
module pvu_term import pvu_pkg::*; (
    input  logic                     i_clk,
    input  t_pipe_ctl                i_ctl,
    input  logic [GAIN_W-1:0]        i_gain,
    input  logic signed [DIFF_W-1:0] i_x,
    output logic signed [TERM_W-1:0] o_term
);

    localparam int P1_W = HALF_W + RECIP_W;
    localparam int P2_W = CHUNK_W + RECIP_W;

    logic                    r_neg_s2, r_neg_s3, r_neg_s4, r_neg_s5, r_neg_s6, r_neg_s7;
    logic [DIFF_W-1:0]       r_mag;
    logic [PROD_W-1:0]       r_n;
    logic [HALF_W-1:0]       r_nhi;
    logic [HALF_W-1:0]       r_nlo_s4, r_nlo_s5;
    logic [P1_W-1:0]         r_prod1;
    logic [QHI_W-1:0]        r_q1_s5, r_q1_s6;
    logic [REM_W-1:0]        r_r1;
    logic [CHUNK_W-1:0]      r_t;
    logic [P2_W-1:0]         r_prod2;
    logic [QUO_W-1:0]        r_q;
    logic signed [TERM_W-1:0] r_term;

    logic [PROD_W:0]         w_n;
    logic [QHI_W-1:0]        w_q1e;
    logic [HALF_W:0]         w_r1e;
    logic [QHI_W-1:0]        w_q1;
    logic [REM_W-1:0]        w_r1;
    logic [HALF_W:0]         w_q2e;
    logic [CHUNK_W:0]        w_r2e;
    logic [HALF_W-1:0]       w_q2;

    always_comb begin
        w_n   = (PROD_W+1)'(i_gain) * (PROD_W+1)'(r_mag) + (PROD_W+1)'(ROUND_UP);
        w_q1e = r_prod1[P1_W-1:RECIP_SH];
        w_r1e = (HALF_W+1)'(r_nhi) - (HALF_W+1)'(w_q1e) * (HALF_W+1)'(SCALE);
        if (w_r1e[REM_W:0] >= (REM_W+1)'(SCALE)) begin
            w_q1 = w_q1e + QHI_W'(1);
            w_r1 = REM_W'(w_r1e[REM_W:0] - (REM_W+1)'(SCALE));
        end else begin
            w_q1 = w_q1e;
            w_r1 = w_r1e[REM_W-1:0];
        end
        w_q2e = r_prod2[P2_W-1:RECIP_SH];
        w_r2e = (CHUNK_W+1)'(r_t) - (CHUNK_W+1)'(w_q2e) * (CHUNK_W+1)'(SCALE);
        if (w_r2e[REM_W:0] >= (REM_W+1)'(SCALE)) begin
            w_q2 = HALF_W'(w_q2e + (HALF_W+1)'(1));
        end else begin
            w_q2 = w_q2e[HALF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[STG_MAG]) begin
            r_neg_s2 <= i_x[DIFF_W-1];
            r_mag    <= i_x[DIFF_W-1] ? DIFF_W'(-i_x) : DIFF_W'(i_x);
        end
        if (i_ctl.adv[STG_MUL]) begin
            r_neg_s3 <= r_neg_s2;
            r_n      <= w_n[PROD_W-1:0];
        end
        if (i_ctl.adv[STG_REC1]) begin
            r_neg_s4 <= r_neg_s3;
            r_nhi    <= r_n[PROD_W-1:HALF_W];
            r_nlo_s4 <= r_n[HALF_W-1:0];
            r_prod1  <= P1_W'(r_n[PROD_W-1:HALF_W]) * P1_W'(RECIP_100);
        end
        if (i_ctl.adv[STG_DIV1]) begin
            r_neg_s5 <= r_neg_s4;
            r_q1_s5  <= w_q1;
            r_r1     <= w_r1;
            r_nlo_s5 <= r_nlo_s4;
        end
        if (i_ctl.adv[STG_REC2]) begin
            r_neg_s6 <= r_neg_s5;
            r_q1_s6  <= r_q1_s5;
            r_t      <= {r_r1, r_nlo_s5};
            r_prod2  <= P2_W'({r_r1, r_nlo_s5}) * P2_W'(RECIP_100);
        end
        if (i_ctl.adv[STG_DIV2]) begin
            r_neg_s7 <= r_neg_s6;
            r_q      <= {r_q1_s6, w_q2};
        end
        if (i_ctl.adv[STG_TERM]) begin
            r_term <= r_neg_s7 ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        end
    end

    assign o_term = r_term;

endmodule

### sv/pvu_combine.sv
// Sum of the three terms, velocity saturation and guarded position update.
module pvu_combine import pvu_pkg::*; (
    input  logic                     i_clk,
    input  t_pipe_ctl                i_ctl,
    input  logic signed [TERM_W-1:0] i_term_v,
    input  logic signed [TERM_W-1:0] i_term_p,
    input  logic signed [TERM_W-1:0] i_term_g,
    input  logic signed [WORD_W-1:0] i_pos,
    output t_pvu_out                 o_data
);

    logic signed [SUM_W-1:0]  r_sum;
    logic signed [WORD_W-1:0] r_pos_s9, r_pos_s10;
    logic signed [WORD_W-1:0] r_nv;
    t_pvu_out                 r_out;

    logic signed [WORD_W-1:0] w_sat;
    logic signed [WORD_W:0]   w_np;
    logic                     w_fits;

    always_comb begin
        w_fits = (r_sum[SUM_W-1:WORD_W-1] == '0) || (r_sum[SUM_W-1:WORD_W-1] == '1);
        if (w_fits) begin
            w_sat = r_sum[WORD_W-1:0];
        end else if (r_sum[SUM_W-1]) begin
            w_sat = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(WORD_W-1){1'b1}}};
        end
        w_np = (WORD_W+1)'(r_pos_s10) + (WORD_W+1)'(r_nv);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[STG_SUM]) begin
            r_sum    <= SUM_W'(i_term_v) + SUM_W'(i_term_p) + SUM_W'(i_term_g);
            r_pos_s9 <= i_pos;
        end
        if (i_ctl.adv[STG_SAT]) begin
            r_nv      <= w_sat;
            r_pos_s10 <= r_pos_s9;
        end
        if (i_ctl.adv[STG_OUT]) begin
            r_out.new_velocity <= r_nv;
            r_out.new_position <= (w_np[WORD_W] != w_np[WORD_W-1]) ? r_pos_s10
                                                                     : w_np[WORD_W-1:0];
        end
    end

    assign o_data = r_out;

endmodule

### sv/pso_velocity_position_update_top.sv
// Swarm element velocity and position update, top level.
// The block takes one transfer per clock while o_stall is low and passes
// each through the twelve-register pipeline: input capture, differences,
// magnitudes, gain products, two chunked reciprocal divisions by 100, sign
// restore, three-term sum, saturation and the position output
// register. Each stage advances whenever it is empty or the stage after it
// advances, so gaps close up under an output stall and new transfers keep
// entering until every stage is full. Gains are read from the configuration
// registers as items pass and should be changed only while the pipeline is
// empty.
module pso_velocity_position_update_top import pvu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_pvu_in           i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_pvu_out          o_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [NUM_STAGES-1:0]    r_vld;
    t_pipe_ctl                w_ctl;
    t_pvu_gains               w_gains;
    t_pvu_in                  r_in;
    logic signed [DIFF_W-1:0] r_xv, r_xp, r_xg;
    logic signed [WORD_W-1:0] r_pos [STG_DIFF:STG_TERM];
    logic signed [TERM_W-1:0] w_term_v, w_term_p, w_term_g;

    always_comb begin
        w_ctl.adv[STG_OUT] = !r_vld[STG_OUT] || !i_stall;
        for (int k = STG_OUT - 1; k >= 0; k--) begin
            w_ctl.adv[k] = !r_vld[k] || w_ctl.adv[k+1];
        end
    end

    assign o_stall = !w_ctl.adv[STG_IN];
    assign o_valid = r_vld[STG_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ctl.adv[STG_IN]) begin
                r_vld[STG_IN] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_ctl.adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.adv[STG_IN]) begin
            r_in <= i_data;
        end
        if (w_ctl.adv[STG_DIFF]) begin
            r_xv <= DIFF_W'(r_in.velocity);
            r_xp <= DIFF_W'(r_in.personal_best) - DIFF_W'(r_in.position);
            r_xg <= DIFF_W'(r_in.global_best) - DIFF_W'(r_in.position);
            r_pos[STG_DIFF] <= r_in.position;
        end
        for (int k = STG_DIFF + 1; k <= STG_TERM; k++) begin
            if (w_ctl.adv[k]) begin
                r_pos[k] <= r_pos[k-1];
            end
        end
    end

    pvu_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (w_gains)
    );

    pvu_term u_term_v (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_gain (w_gains.inertia_pct),
        .i_x    (r_xv),
        .o_term (w_term_v)
    );

    pvu_term u_term_p (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_gain (w_gains.personal_pct),
        .i_x    (r_xp),
        .o_term (w_term_p)
    );

    pvu_term u_term_g (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_gain (w_gains.global_pct),
        .i_x    (r_xg),
        .o_term (w_term_g)
    );

    pvu_combine u_combine (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_term_v (w_term_v),
        .i_term_p (w_term_p),
        .i_term_g (w_term_g),
        .i_pos    (r_pos[STG_TERM]),
        .o_data   (o_data)
    );

endmodule

### sv/pvu_checker.sv
// Port-level checks for the swarm update block, bound to the top level.
module pvu_checker import pvu_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input t_pvu_out          o_data,
    input logic              pready
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output side can move");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port not ready");

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result dropped");

    a_out_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("stalled result changed");

endmodule

bind pso_velocity_position_update_top pvu_checker u_checker (.*);
